@@ rtl/cdad_pkg.sv @@
package cdad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 15;

  // year / 100 by reciprocal: exact for every 14-bit year
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int ProdW      = YearW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;
  localparam int RemW       = 7;

  localparam logic [RecipW-1:0] RECIP_100  = RecipW'(5243);
  localparam logic [YearW-1:0]  YEAR_MAX   = YearW'(9999);
  localparam logic [MonthW-1:0] MONTH_JAN  = MonthW'(1);
  localparam logic [MonthW-1:0] MONTH_FEB  = MonthW'(2);
  localparam logic [MonthW-1:0] MONTH_DEC  = MonthW'(12);
  localparam logic [RemW-1:0]   REM_LAST   = RemW'(99);
  localparam logic [DayW-1:0]   DAY_FIRST  = DayW'(1);
  localparam logic [DayW-1:0]   FEB_LEAP   = DayW'(29);

  localparam logic [DayW-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    len = '0;
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP;
    end else if (m <= MONTH_DEC) begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

@@ rtl/cdad_ctrl.sv @@
module cdad_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  cdad_pkg::sts_t  sts,
  output cdad_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    CHECK = 4'b0010,
    STEP  = 4'b0100,
    FIN   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        cmd.check  = 1'b1;
        state_next = STEP;
      end
      STEP: begin
        if (sts.done) begin
          state_next = FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      FIN: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/cdad_dp.sv @@
module cdad_dp (
  input  logic                          clk,
  input  cdad_pkg::cmd_t                cmd,
  output cdad_pkg::sts_t                sts,
  input  logic [cdad_pkg::DayW-1:0]     start_day,
  input  logic [cdad_pkg::MonthW-1:0]   start_month,
  input  logic [cdad_pkg::YearW-1:0]    start_year,
  input  logic [cdad_pkg::CountW-1:0]   days_to_add,
  output logic [cdad_pkg::DayW-1:0]     end_day,
  output logic [cdad_pkg::MonthW-1:0]   end_month,
  output logic [cdad_pkg::YearW-1:0]    end_year,
  output logic                          input_invalid,
  output logic                          year_overflow
);

  logic [cdad_pkg::DayW-1:0]   d;
  logic [cdad_pkg::MonthW-1:0] m;
  logic [cdad_pkg::YearW-1:0]  y;
  logic [cdad_pkg::CountW-1:0] n;
  logic [cdad_pkg::QuotW-1:0]  q;
  logic [cdad_pkg::RemW-1:0]   r100;
  logic [1:0]                  q4;
  logic                        invalid;
  logic                        ovf;

  logic [cdad_pkg::ProdW-1:0]  prod;
  logic [cdad_pkg::YearW:0]    hundreds;
  logic [cdad_pkg::YearW:0]    rem_wide;
  logic [cdad_pkg::RemW-1:0]   rem_c;
  logic                        leap;
  logic [cdad_pkg::DayW-1:0]   mlen;
  logic                        bad;

  assign prod     = cdad_pkg::ProdW'(start_year) * cdad_pkg::ProdW'(cdad_pkg::RECIP_100);
  assign hundreds = (cdad_pkg::YearW+1)'(q) * (cdad_pkg::YearW+1)'(100);
  assign rem_wide = (cdad_pkg::YearW+1)'(y) - hundreds;
  assign rem_c    = rem_wide[cdad_pkg::RemW-1:0];

  // leap: y%4 == 0 and (y%100 != 0 or (y/100)%4 == 0)
  always_comb begin
    if (cmd.check) begin
      leap = (y[1:0] == 2'b00) && ((rem_c != '0) || (q[1:0] == 2'b00));
    end else begin
      leap = (y[1:0] == 2'b00) && ((r100 != '0) || (q4 == 2'b00));
    end
  end

  assign mlen = cdad_pkg::month_days(m, leap);
  assign bad  = (m == '0) || (m > cdad_pkg::MONTH_DEC) || (y > cdad_pkg::YEAR_MAX) ||
                (d == '0) || (d > mlen);

  assign sts.done = (n == '0) || ovf || invalid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d       <= start_day;
      m       <= start_month;
      y       <= start_year;
      n       <= days_to_add;
      q       <= prod[cdad_pkg::ProdW-1:cdad_pkg::RecipShift];
      ovf     <= 1'b0;
      invalid <= 1'b0;
    end
    if (cmd.check) begin
      r100    <= rem_c;
      q4      <= q[1:0];
      invalid <= bad;
    end
    if (cmd.step) begin
      n <= n - cdad_pkg::CountW'(1);
      if (d == mlen) begin
        if (m == cdad_pkg::MONTH_DEC) begin
          if (y == cdad_pkg::YEAR_MAX) begin
            ovf <= 1'b1;
          end else begin
            y <= y + cdad_pkg::YearW'(1);
            m <= cdad_pkg::MONTH_JAN;
            d <= cdad_pkg::DAY_FIRST;
            if (r100 == cdad_pkg::REM_LAST) begin
              r100 <= '0;
              q4   <= q4 + 2'd1;
            end else begin
              r100 <= r100 + cdad_pkg::RemW'(1);
            end
          end
        end else begin
          m <= m + cdad_pkg::MonthW'(1);
          d <= cdad_pkg::DAY_FIRST;
        end
      end else begin
        d <= d + cdad_pkg::DayW'(1);
      end
    end
    if (cmd.publish) begin
      end_day       <= d;
      end_month     <= m;
      end_year      <= y;
      input_invalid <= invalid;
      year_overflow <= ovf;
    end
  end

endmodule

@@ rtl/calendar_date_add_days.sv @@
// Channel  Handshake                 Payload
// in       in_valid / in_stall       start_day, start_month, start_year, days_to_add
// out      out_valid / out_stall     end_day, end_month, end_year, input_invalid,
//                                    year_overflow
//
// One request at a time: load on acceptance, then one date check, one step per
// day added, one state to end the stepping, and a publish that waits while a
// result already held in the output register is stalled.
// An invalid date or passing 31 Dec 9999 ends the stepping early.
// The result register frees the stepper, so the next request is taken
// while a result waits under out_stall. rst is synchronous and clears control only.
module calendar_date_add_days (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdad_pkg::DayW-1:0]     start_day,
  input  logic [cdad_pkg::MonthW-1:0]   start_month,
  input  logic [cdad_pkg::YearW-1:0]    start_year,
  input  logic [cdad_pkg::CountW-1:0]   days_to_add,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdad_pkg::DayW-1:0]     end_day,
  output logic [cdad_pkg::MonthW-1:0]   end_month,
  output logic [cdad_pkg::YearW-1:0]    end_year,
  output logic                          input_invalid,
  output logic                          year_overflow
);

  cdad_pkg::cmd_t cmd;
  cdad_pkg::sts_t sts;

  cdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdad_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .days_to_add   (days_to_add),
    .end_day       (end_day),
    .end_month     (end_month),
    .end_year      (end_year),
    .input_invalid (input_invalid),
    .year_overflow (year_overflow)
  );

endmodule
